FILE: rtl/slce_pkg.sv
// ----------------------------------------------------------------------------
// slce_pkg
// Shared types and constants of the serpentine line command encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package slce_pkg;

	localparam int unsigned COORD_W   = 32;
	localparam int unsigned DELTA_W   = 33;
	localparam int unsigned CMD_W     = 3;
	localparam int unsigned CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 1'b1;

	// plotter command codes
	localparam logic [CMD_W-1:0] CMD_PEN_UP  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CONT_UP = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ONLY    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_START   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_MIDDLE  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_END     = 3'd5;

	// one buffered segment, first endpoint in the low bits
	typedef struct packed {
		logic signed [COORD_W-1:0] by;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] ax;
	} seg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_MOVE,
		ST_DRAW
	} seq_state_t;

	// one result item
	typedef struct packed {
		logic [CMD_W-1:0]          cmd;
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
		logic                      ovf;
		logic                      last;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/slce_seg_mem.sv
// ----------------------------------------------------------------------------
// slce_seg_mem
// Segment buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module slce_seg_mem #(
	parameter int unsigned DEPTH  = 32,
	parameter int unsigned ADDR_W = 5
) (
	input  wire                        clk,
	input  wire                        we,
	input  wire [ADDR_W-1:0]           waddr,
	input  slce_pkg::seg_t             wdata,
	input  wire                        re,
	input  wire [ADDR_W-1:0]           raddr,
	output slce_pkg::seg_t             rdata
);
	import slce_pkg::*;

	seg_t mem_q [DEPTH];
	seg_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/slce_seq.sv
// ----------------------------------------------------------------------------
// slce_seq
// Group collection and command sequencer: stores segments, then walks the
// buffer in serpentine order and emits move/draw commands through an
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slce_seq #(
	parameter int unsigned MAX_SEGMENTS = 32,
	parameter int unsigned IDX_W        = 5,
	parameter int unsigned CNT_W        = 6
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// segment input
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire                                in_group_last,
	input  wire                                in_job_start,
	// configuration
	input  wire signed [slce_pkg::COORD_W-1:0] origin_x,
	input  wire signed [slce_pkg::COORD_W-1:0] origin_y,
	// buffer ports
	output logic                               mem_we,
	output logic [IDX_W-1:0]                   mem_waddr,
	output logic                               mem_re,
	output logic [IDX_W-1:0]                   mem_raddr,
	input  slce_pkg::seg_t                     mem_rdata,
	// command output
	output logic                               out_valid,
	input  wire                                out_ready,
	output slce_pkg::result_t                  out_res
);
	import slce_pkg::*;

	seq_state_t state_q, state_d;

	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          c_q;
	logic                      ovf_q;
	logic                      fwd_q;
	logic signed [COORD_W-1:0] last_x_q, last_y_q;
	logic                      out_valid_q;
	result_t                   out_res_q;

	logic                      accept;
	logic                      out_free;
	logic                      out_load;
	logic                      seg_done;
	logic                      group_done;
	logic [CNT_W-1:0]          base_cnt;
	logic                      base_ovf;
	logic                      room;
	logic [CNT_W-1:0]          c_next;
	logic [CNT_W-1:0]          rd_idx;
	logic                      is_last_seg;
	logic signed [COORD_W-1:0] p1x, p1y, p2x, p2y;
	result_t                   res_d;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign base_cnt = in_job_start ? '0 : count_q;
	assign base_ovf = in_job_start ? 1'b0 : ovf_q;
	assign room     = base_cnt < CNT_W'(MAX_SEGMENTS);

	assign is_last_seg = c_q == (count_q - CNT_W'(1));

	// walk order: forward by position, backward from the top of the group
	assign c_next = (state_q == ST_READ) ? c_q : c_q + CNT_W'(1);
	assign rd_idx = fwd_q ? c_next : (count_q - CNT_W'(1) - c_next);

	always_comb begin
		if (fwd_q) begin
			p1x = mem_rdata.ax;
			p1y = mem_rdata.ay;
			p2x = mem_rdata.bx;
			p2y = mem_rdata.by;
		end else begin
			p1x = mem_rdata.bx;
			p1y = mem_rdata.by;
			p2x = mem_rdata.ax;
			p2y = mem_rdata.ay;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_group_last) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_MOVE;
			end
			ST_MOVE: begin
				if (out_free) begin
					state_d = ST_DRAW;
				end
			end
			ST_DRAW: begin
				if (out_free) begin
					state_d = is_last_seg ? ST_IDLE : ST_MOVE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready   = 1'b0;
		out_load   = 1'b0;
		seg_done   = 1'b0;
		group_done = 1'b0;
		mem_re     = 1'b0;
		res_d.cmd  = CMD_PEN_UP;
		res_d.dx   = {p1x[COORD_W-1], p1x} - {last_x_q[COORD_W-1], last_x_q};
		res_d.dy   = {p1y[COORD_W-1], p1y} - {last_y_q[COORD_W-1], last_y_q};
		res_d.ovf  = ovf_q;
		res_d.last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_READ: begin
				mem_re = 1'b1;
			end
			ST_MOVE: begin
				out_load  = out_free;
				res_d.cmd = (c_q == '0) ? CMD_PEN_UP : CMD_CONT_UP;
			end
			ST_DRAW: begin
				out_load   = out_free;
				seg_done   = out_free;
				group_done = out_free && is_last_seg;
				mem_re     = out_free && !is_last_seg;
				res_d.dx   = {p2x[COORD_W-1], p2x} - {p1x[COORD_W-1], p1x};
				res_d.dy   = {p2y[COORD_W-1], p2y} - {p1y[COORD_W-1], p1y};
				res_d.last = is_last_seg;
				if (count_q == CNT_W'(1)) begin
					res_d.cmd = CMD_ONLY;
				end else if (c_q == '0) begin
					res_d.cmd = CMD_START;
				end else if (is_last_seg) begin
					res_d.cmd = CMD_END;
				end else begin
					res_d.cmd = CMD_MIDDLE;
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign mem_we    = accept && room;
	assign mem_waddr = base_cnt[IDX_W-1:0];
	assign mem_raddr = rd_idx[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			c_q         <= '0;
			ovf_q       <= 1'b0;
			fwd_q       <= 1'b1;
			last_x_q    <= '0;
			last_y_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				c_q     <= '0;
				count_q <= room ? base_cnt + CNT_W'(1) : base_cnt;
				ovf_q   <= room ? base_ovf : 1'b1;
				if (in_job_start) begin
					fwd_q    <= 1'b1;
					last_x_q <= origin_x;
					last_y_q <= origin_y;
				end
			end
			if (seg_done) begin
				c_q      <= c_q + CNT_W'(1);
				last_x_q <= p2x;
				last_y_q <= p2y;
			end
			if (group_done) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				fwd_q   <= !fwd_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

`default_nettype wire

FILE: rtl/serpentine_line_command_encoder_top.sv
// ----------------------------------------------------------------------------
// serpentine_line_command_encoder_top
// Buffers the segments of a scan row and replays them as relative move/draw
// plotter commands, alternating walk direction from row to row.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   tvalid/tready      segment endpoints, tlast = group end,
//                                   tuser = job start
//  m_*      out  tvalid/tready      command deltas, tuser = command/overflow,
//                                   tlast = final command of the group
//  cfg_*    in   cfg_we             origin_x / origin_y
//
//  Segments are taken back to back while idle. After a group's last segment
//  the block emits its n buffered segments: one buffer read lead-in, then
//  two commands per segment, move and draw, through the single read port.
//  s_tready is low during emission; the output register lets the final
//  command wait while the next group loads. m_tready low stalls emission.
//  arst_n clears the segment count, direction (forward), last point and
//  origin; buffer contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module serpentine_line_command_encoder_top #(
	parameter int unsigned MAX_SEGMENTS = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// configuration
	input  wire                              cfg_we,
	input  wire [slce_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [slce_pkg::COORD_W-1:0]      cfg_wdata,
	// segment input
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// seg_start_x[31:0], seg_start_y[63:32], seg_end_x[95:64], seg_end_y[127:96]
	input  wire [127:0]                      s_tdata,
	input  wire                              s_tlast,   // group_last
	input  wire                              s_tuser,   // job_start
	// command output
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// delta_x[32:0], delta_y[65:33], zero pad [71:66]
	output logic [71:0]                      m_tdata,
	// command[2:0], overflow[3]
	output logic [3:0]                       m_tuser,
	output logic                             m_tlast    // run_last
);
	import slce_pkg::*;

	localparam int unsigned IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);

	logic signed [COORD_W-1:0] origin_x_q, origin_y_q;

	seg_t             in_seg;
	logic             mem_we, mem_re;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;
	seg_t             mem_rdata;
	result_t          res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_X: origin_x_q <= cfg_wdata;
				REG_ORIGIN_Y: origin_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_seg.ax = s_tdata[31:0];
	assign in_seg.ay = s_tdata[63:32];
	assign in_seg.bx = s_tdata[95:64];
	assign in_seg.by = s_tdata[127:96];

	slce_seg_mem #(
		.DEPTH  (MAX_SEGMENTS),
		.ADDR_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (in_seg),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	slce_seq #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.IDX_W        (IDX_W),
		.CNT_W        (CNT_W)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_group_last (s_tlast),
		.in_job_start  (s_tuser),
		.origin_x      (origin_x_q),
		.origin_y      (origin_y_q),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_re        (mem_re),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_res       (res)
	);

	assign m_tdata = {6'b0, res.dy, res.dx};
	assign m_tuser = {res.ovf, res.cmd};
	assign m_tlast = res.last;

endmodule

`default_nettype wire

FILE: rtl/slce_checker.sv
// ----------------------------------------------------------------------------
// slce_checker
// Port-level checks of the serpentine line command encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module slce_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        s_tlast,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [71:0] m_tdata,
	input wire [3:0]  m_tuser,
	input wire        m_tlast
);
	import slce_pkg::*;

	// a group end starts emission, so no segment is taken the next cycle
	a_group_end_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("segment input ready right after group end");

	// a stalled transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output transaction changed while stalled");

	// moves never close a group
	a_move_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] == CMD_PEN_UP || m_tuser[2:0] == CMD_CONT_UP)
			|-> !m_tlast)
		else $error("move command flagged as group end");

	// only and end draws always close the group
	a_final_draw_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] == CMD_ONLY || m_tuser[2:0] == CMD_END)
			|-> m_tlast)
		else $error("final draw without group end");

	// a valid command right after a taken group end is a pen-up or does not close a group
	a_after_last_pen_up: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast ##1 m_tvalid
			|-> m_tuser[2:0] == CMD_PEN_UP || m_tlast == 1'b0)
		else $error("group did not restart with pen up");

endmodule

bind serpentine_line_command_encoder_top slce_checker u_slce_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the serpentine line command encoder. Segment groups
// are streamed in with random gaps while the command stream is stalled at
// random. A scoreboard replays each accepted segment through its own copy of
// the buffer, walk direction and head position, and compares every command
// transaction in order against the predicted move/draw sequence.
// ----------------------------------------------------------------------------

module testbench;

	import slce_pkg::*;

	localparam int MAX_SEGS = 32;
	localparam logic [COORD_W-1:0] C_MIN = 32'h8000_0000;
	localparam logic [COORD_W-1:0] C_MAX = 32'h7fff_ffff;

	typedef struct {
		seg_t seg;
		bit   group_last;
		bit   job_start;
	} seg_item_t;

	class command_scoreboard;
		seg_t                      rows [MAX_SEGS];
		int                        held;
		bit                        fwd;
		bit                        dropped;
		logic signed [COORD_W-1:0] head_x, head_y;
		logic signed [COORD_W-1:0] org_x, org_y;
		result_t                   expected_cmds [$];
		int                        errors;

		function new();
			held = 0;
			fwd = 1'b1;
			dropped = 1'b0;
			head_x = '0;
			head_y = '0;
			org_x = '0;
			org_y = '0;
			errors = 0;
		endfunction

		function void set_origin(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
			org_x = x;
			org_y = y;
		endfunction

		function void push_cmd(logic [CMD_W-1:0] cmd, logic signed [DELTA_W-1:0] dx,
				logic signed [DELTA_W-1:0] dy, bit last);
			result_t r;
			r.cmd = cmd;
			r.dx = dx;
			r.dy = dy;
			r.ovf = dropped;
			r.last = last;
			expected_cmds = {expected_cmds, r};
		endfunction

		// predicts the commands released by one accepted segment
		function void take_segment(seg_item_t it);
			seg_t                      s;
			logic signed [COORD_W-1:0] p1x, p1y, p2x, p2y;
			logic signed [DELTA_W-1:0] mdx, mdy, ddx, ddy;
			logic [CMD_W-1:0]          move_cmd, draw_cmd;
			int                        n, idx;
			if (it.job_start) begin
				fwd = 1'b1;
				head_x = org_x;
				head_y = org_y;
				held = 0;
				dropped = 1'b0;
			end
			if (held < MAX_SEGS) begin
				rows[held] = it.seg;
				held++;
			end else begin
				dropped = 1'b1;
			end
			if (!it.group_last)
				return;
			n = held;
			for (int c = 0; c < n; c++) begin
				idx = fwd ? c : n - 1 - c;
				s = rows[idx];
				if (fwd) begin
					p1x = s.ax; p1y = s.ay; p2x = s.bx; p2y = s.by;
				end else begin
					p1x = s.bx; p1y = s.by; p2x = s.ax; p2y = s.ay;
				end
				if (n == 1) begin
					move_cmd = CMD_PEN_UP; draw_cmd = CMD_ONLY;
				end else if (c == 0) begin
					move_cmd = CMD_PEN_UP; draw_cmd = CMD_START;
				end else if (c == n - 1) begin
					move_cmd = CMD_CONT_UP; draw_cmd = CMD_END;
				end else begin
					move_cmd = CMD_CONT_UP; draw_cmd = CMD_MIDDLE;
				end
				mdx = p1x - head_x;
				mdy = p1y - head_y;
				ddx = p2x - p1x;
				ddy = p2y - p1y;
				push_cmd(move_cmd, mdx, mdy, 1'b0);
				push_cmd(draw_cmd, ddx, ddy, c == n - 1);
				head_x = p2x;
				head_y = p2y;
			end
			held = 0;
			dropped = 1'b0;
			fwd = !fwd;
		endfunction

		function void check_command(result_t got);
			result_t want;
			if (expected_cmds.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%t unexpected command: cmd %0d dx %0d dy %0d ovf %0b last %0b",
						$realtime, got.cmd, got.dx, got.dy, got.ovf, got.last);
				return;
			end
			want = expected_cmds.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("%t command mismatch: exp cmd %0d dx %0d dy %0d ovf %0b last %0b | got cmd %0d dx %0d dy %0d ovf %0b last %0b",
						$realtime, want.cmd, want.dx, want.dy, want.ovf, want.last,
						got.cmd, got.dx, got.dy, got.ovf, got.last);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0]   cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [127:0]         s_tdata = '0;    // seg_start_x, seg_start_y, seg_end_x, seg_end_y
	logic                 s_tlast = 1'b0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [71:0]          m_tdata;         // delta_x, delta_y, zero pad
	logic [3:0]           m_tuser;         // command, overflow
	logic                 m_tlast;

	command_scoreboard scb;
	int                idle_pct = 19;

	serpentine_line_command_encoder_top #(
		.MAX_SEGMENTS(MAX_SEGS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.cmd = m_tuser[2:0];
			got.ovf = m_tuser[3];
			got.dx = m_tdata[32:0];
			got.dy = m_tdata[65:33];
			got.last = m_tlast;
			scb.check_command(got);
		end
	end

	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(7))
			0: return C_MIN;
			1: return C_MAX;
			2: return '0;
			3: return '1;
			4, 5: return $urandom_range(2000) - 1000;
			default: return $urandom();
		endcase
	endfunction

	// entered at a falling edge; leaves s_tvalid high, so the caller drives
	// it again at the falling edge where this returns
	task automatic send_segment(input seg_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= it.seg;
		s_tlast <= it.group_last;
		s_tuser <= it.job_start;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		scb.take_segment(it);
		@(negedge clk);
	endtask

	task automatic send_coords(input logic [COORD_W-1:0] ax, ay, bx, by,
			input bit gl, input bit js);
		seg_item_t it;
		it.seg.ax = ax;
		it.seg.ay = ay;
		it.seg.bx = bx;
		it.seg.by = by;
		it.group_last = gl;
		it.job_start = js;
		send_segment(it);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (scb.expected_cmds.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic set_origin(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		cfg_we <= 1'b1;
		cfg_index <= REG_ORIGIN_X;
		cfg_wdata <= x;
		@(negedge clk);
		cfg_index <= REG_ORIGIN_Y;
		cfg_wdata <= y;
		@(negedge clk);
		cfg_we <= 1'b0;
		scb.set_origin(x, y);
	endtask

	task automatic run_directed();
		// single segment job: pen up + only, widest deltas
		send_coords(C_MIN, C_MAX, C_MAX, C_MIN, 1, 1);
		// odd row walked backward with swapped endpoints
		send_coords(C_MAX, C_MAX, C_MIN, C_MIN, 0, 0);
		send_coords(1, 2, 3, 4, 0, 0);
		send_coords(-1, -1, C_MAX, 0, 1, 0);
		// two segment forward row: start then end
		send_coords(10, 20, 30, 40, 0, 0);
		send_coords(-50, 60, 70, -80, 1, 0);
		// job start mid-row throws away the partial row
		send_coords(100, 100, 200, 200, 0, 0);
		send_coords(300, 300, 400, 400, 0, 0);
		send_coords(7, 8, 9, 10, 1, 1);
		// backward single segment
		send_coords(5, 6, C_MIN, C_MAX, 1, 0);
		// forward row with start/middle/end and opposite extreme move
		send_coords(C_MIN, C_MIN, C_MAX, C_MAX, 0, 0);
		send_coords(C_MIN, C_MIN, 0, 0, 0, 0);
		send_coords(pick_coord(), pick_coord(), pick_coord(), pick_coord(), 0, 0);
		send_coords(0, 0, 0, 0, 1, 0);
	endtask

	task automatic run_random(input int budget, input bit force_overflow);
		seg_item_t it;
		int        sent, size;
		bit        js;
		sent = 0;
		while (sent < budget) begin
			if (force_overflow)
				size = $urandom_range(36, 33);
			else if ($urandom_range(99) < 10)
				size = $urandom_range(36, 30);
			else
				size = $urandom_range(6, 1);
			force_overflow = 1'b0;
			js = ($urandom_range(99) < 20);
			for (int k = 0; k < size; k++) begin
				it.seg.ax = pick_coord();
				it.seg.ay = pick_coord();
				it.seg.bx = pick_coord();
				it.seg.by = pick_coord();
				it.group_last = (k == size - 1);
				// occasional stray job start breaks a row in the middle
				it.job_start = (k == 0 && js) || ($urandom_range(99) < 3);
				send_segment(it);
				sent++;
			end
		end
	endtask

	initial begin
		scb = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();
		drain();

		for (int phase = 1; phase <= 4; phase++) begin
			case (phase)
				1: set_origin(C_MIN, C_MAX);
				2: set_origin(C_MAX, C_MIN);
				3: set_origin($urandom(), $urandom());
				default: set_origin('0, '1);
			endcase
			// one phase runs with no input gaps and the output always ready
			idle_pct = (phase == 2) ? 0 : 19;
			run_random(35, phase == 3);
			drain();
		end

		if (scb.errors == 0 && scb.expected_cmds.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
